// ----- src/pbrle_pkg.sv -----
// Package for the PackBits run-length encoder.
// Holds the sequencer state and mode types, the coded byte struct and fixed codes.
// No dependencies.
`default_nettype none

package pbrle_pkg;

	localparam int BYTES_PER_WORD = 8;

	// Header base for a repeat: the header byte is this value less the repeat length.
	localparam logic [8:0] RUN_HDR_BASE = 9'd257;

	// End-of-stream marker byte.
	localparam logic [7:0] END_MARK = 8'd128;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_LIT,
		MODE_RUN
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_LIT_HDR,
		ST_LIT_BODY,
		ST_RUN_HDR,
		ST_RUN_BYTE,
		ST_PUSH,
		ST_FLUSH,
		ST_MARK
	} state_t;

	// One coded byte on its way from the sequencer to the packer.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
		logic       done;
	} sym_t;

endpackage

`default_nettype wire

// ----- src/pbrle_in_if.sv -----
// Input channel of the PackBits encoder: one image byte per word.
// Stand-alone interface, no dependencies.
`default_nettype none

interface pbrle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       end_of_image;

	modport source (output valid, output pixel, output end_of_image, input ready);
	modport sink   (input valid, input pixel, input end_of_image, output ready);
endinterface

`default_nettype wire

// ----- src/pbrle_out_if.sv -----
// Output channel of the PackBits encoder: up to eight coded bytes per word.
// Stand-alone interface, no dependencies.
`default_nettype none

interface pbrle_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        last_of_run;
	logic        stream_done;

	modport source (output valid, output out_bytes, output byte_count,
		output last_of_run, output stream_done, input ready);
	modport sink   (input valid, input out_bytes, input byte_count,
		input last_of_run, input stream_done, output ready);
endinterface

`default_nettype wire

// ----- src/pbrle_store.sv -----
// Literal store of the PackBits encoder: single write port, one registered read port.
// No dependencies.
`default_nettype none

module pbrle_store #(
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [7:0]               wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [7:0]               rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- src/pbrle_seq.sv -----
// Group sequencer of the PackBits encoder: decides runs and literal groups and
// issues the coded bytes one per cycle while sym_ready holds. Uses pbrle_pkg and pbrle_store.
`default_nettype none

module pbrle_seq #(
	parameter int MAX_GROUP = 128
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       pixel,
	input  wire logic             end_of_image,
	output pbrle_pkg::sym_t       sym,
	input  wire logic             sym_ready
);

	localparam int CW = $clog2(MAX_GROUP + 1);
	localparam int AW = $clog2(MAX_GROUP);

	pbrle_pkg::state_t state_q, state_d, end_st;
	pbrle_pkg::mode_t  mode_q, mode_d;
	logic [CW-1:0]     count_q, count_d;
	logic [7:0]        prev_q, prev_d;
	logic              prev_vld_q, prev_vld_d;
	logic              flush_q, flush_d;
	logic              push_q, push_d;
	logic [7:0]        pix_q, pix_d;
	logic              eoi_q, eoi_d;
	logic [CW-1:0]     emit_n_q, emit_n_d;
	logic [7:0]        emit_b_q, emit_b_d;
	logic [AW-1:0]     idx_q, idx_d;

	logic              we;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [7:0]        rdata;
	logic              eq, full, fin, take;
	pbrle_pkg::state_t after_st;

	pbrle_store #(.DEPTH(MAX_GROUP)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (pix_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pbrle_pkg::ST_IDLE;
			mode_q     <= pbrle_pkg::MODE_IDLE;
			count_q    <= '0;
			prev_q     <= '0;
			prev_vld_q <= 1'b0;
			flush_q    <= 1'b0;
			push_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			mode_q     <= mode_d;
			count_q    <= count_d;
			prev_q     <= prev_d;
			prev_vld_q <= prev_vld_d;
			flush_q    <= flush_d;
			push_q     <= push_d;
		end
	end

	always_ff @(posedge clk) begin
		pix_q    <= pix_d;
		eoi_q    <= eoi_d;
		emit_n_q <= emit_n_d;
		emit_b_q <= emit_b_d;
		idx_q    <= idx_d;
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		count_d    = count_q;
		prev_d     = prev_q;
		prev_vld_d = prev_vld_q;
		flush_d    = flush_q;
		push_d     = push_q;
		pix_d      = pix_q;
		eoi_d      = eoi_q;
		emit_n_d   = emit_n_q;
		emit_b_d   = emit_b_q;
		idx_d      = idx_q;
		in_ready   = 1'b0;
		we         = 1'b0;
		waddr      = '0;
		raddr      = idx_q;
		sym        = '0;
		fin        = 1'b0;

		eq   = prev_vld_q && (pix_q == prev_q) && (mode_q != pbrle_pkg::MODE_IDLE);
		full = (count_q >= CW'(MAX_GROUP));
		after_st = eoi_q ? pbrle_pkg::ST_FLUSH : pbrle_pkg::ST_IDLE;
		// Where to go once a group has been sent out.
		end_st = flush_q ? pbrle_pkg::ST_MARK :
			(push_q ? pbrle_pkg::ST_PUSH : after_st);
		take = 1'b0;

		case (state_q)
			pbrle_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					pix_d   = pixel;
					eoi_d   = end_of_image;
					state_d = pbrle_pkg::ST_DECIDE;
				end
			end

			pbrle_pkg::ST_DECIDE: begin
				flush_d    = 1'b0;
				push_d     = 1'b0;
				prev_d     = pix_q;
				prev_vld_d = 1'b1;
				if (eq && (mode_q == pbrle_pkg::MODE_LIT)) begin
					// The last literal joins this byte as a run of two.
					mode_d  = pbrle_pkg::MODE_RUN;
					count_d = CW'(2);
					if (count_q > CW'(1)) begin
						emit_n_d = count_q - CW'(1);
						state_d  = pbrle_pkg::ST_LIT_HDR;
					end else begin
						state_d = after_st;
					end
				end else if (eq && full) begin
					// A full run is sent and this byte starts a fresh literal.
					emit_n_d = count_q;
					emit_b_d = pix_q;
					we       = 1'b1;
					mode_d   = pbrle_pkg::MODE_LIT;
					count_d  = CW'(1);
					state_d  = pbrle_pkg::ST_RUN_HDR;
				end else if (eq) begin
					count_d = count_q + CW'(1);
					state_d = after_st;
				end else if (mode_q == pbrle_pkg::MODE_RUN) begin
					emit_n_d = count_q;
					emit_b_d = prev_q;
					we       = 1'b1;
					mode_d   = pbrle_pkg::MODE_LIT;
					count_d  = CW'(1);
					state_d  = pbrle_pkg::ST_RUN_HDR;
				end else if ((mode_q == pbrle_pkg::MODE_LIT) && full) begin
					// The store must be read out before this byte overwrites entry zero.
					emit_n_d = count_q;
					push_d   = 1'b1;
					mode_d   = pbrle_pkg::MODE_LIT;
					count_d  = CW'(1);
					state_d  = pbrle_pkg::ST_LIT_HDR;
				end else begin
					we = 1'b1;
					if (mode_q == pbrle_pkg::MODE_IDLE) begin
						waddr   = '0;
						count_d = CW'(1);
					end else begin
						waddr   = AW'(count_q);
						count_d = count_q + CW'(1);
					end
					mode_d  = pbrle_pkg::MODE_LIT;
					state_d = after_st;
				end
			end

			pbrle_pkg::ST_LIT_HDR: begin
				sym.valid = 1'b1;
				sym.data  = 8'(emit_n_q) - 8'd1;
				raddr     = '0;
				if (sym_ready) begin
					idx_d   = '0;
					state_d = pbrle_pkg::ST_LIT_BODY;
				end
			end

			pbrle_pkg::ST_LIT_BODY: begin
				fin       = (CW'(idx_q) == (emit_n_q - CW'(1)));
				take      = sym_ready;
				sym.valid = 1'b1;
				sym.data  = rdata;
				sym.last  = fin && !flush_q && !eoi_q;
				// Read ahead the next entry only once the current one is taken.
				raddr     = take ? (idx_q + AW'(1)) : idx_q;
				if (take) begin
					idx_d = idx_q + AW'(1);
					if (fin) begin
						state_d = end_st;
					end
				end
			end

			pbrle_pkg::ST_RUN_HDR: begin
				sym.valid = 1'b1;
				sym.data  = 8'(pbrle_pkg::RUN_HDR_BASE - 9'(emit_n_q));
				if (sym_ready) begin
					state_d = pbrle_pkg::ST_RUN_BYTE;
				end
			end

			pbrle_pkg::ST_RUN_BYTE: begin
				sym.valid = 1'b1;
				sym.data  = emit_b_q;
				sym.last  = !flush_q && !eoi_q;
				if (sym_ready) begin
					state_d = end_st;
				end
			end

			pbrle_pkg::ST_PUSH: begin
				we      = 1'b1;
				waddr   = '0;
				push_d  = 1'b0;
				state_d = after_st;
			end

			pbrle_pkg::ST_FLUSH: begin
				flush_d    = 1'b1;
				push_d     = 1'b0;
				emit_n_d   = count_q;
				emit_b_d   = prev_q;
				mode_d     = pbrle_pkg::MODE_IDLE;
				count_d    = '0;
				prev_d     = '0;
				prev_vld_d = 1'b0;
				case (mode_q)
					pbrle_pkg::MODE_LIT: state_d = pbrle_pkg::ST_LIT_HDR;
					pbrle_pkg::MODE_RUN: state_d = pbrle_pkg::ST_RUN_HDR;
					default:             state_d = pbrle_pkg::ST_MARK;
				endcase
			end

			pbrle_pkg::ST_MARK: begin
				sym.valid = 1'b1;
				sym.data  = pbrle_pkg::END_MARK;
				sym.last  = 1'b1;
				sym.done  = 1'b1;
				if (sym_ready) begin
					flush_d = 1'b0;
					state_d = pbrle_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = pbrle_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/pbrle_pack.sv -----
// Byte packer of the PackBits encoder: gathers coded bytes into words of up to
// eight, first byte lowest, and holds the finished word for the output. Uses pbrle_pkg.
`default_nettype none

module pbrle_pack (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pbrle_pkg::sym_t  sym,
	output logic                  sym_ready,
	output logic                  valid,
	input  wire logic             ready,
	output logic [63:0]           out_bytes,
	output logic [3:0]            byte_count,
	output logic                  last_of_run,
	output logic                  stream_done
);

	logic [2:0]  cnt_q;
	logic [63:0] acc_q;
	logic        ovalid_q;
	logic [63:0] odata_q;
	logic [3:0]  ocnt_q;
	logic        olast_q;
	logic        odone_q;

	logic        out_free;
	logic        finish;
	logic        take;
	logic [63:0] merged;

	assign out_free  = !ovalid_q || ready;
	assign finish    = (cnt_q == 3'(pbrle_pkg::BYTES_PER_WORD - 1)) || sym.last;
	// Only a byte that completes a word needs the output register to be free.
	assign sym_ready = !finish || out_free;
	assign take      = sym.valid && sym_ready;
	assign merged    = acc_q | (64'(sym.data) << {cnt_q, 3'b000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			acc_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) begin
				if (finish) begin
					cnt_q <= '0;
					acc_q <= '0;
				end else begin
					cnt_q <= cnt_q + 3'd1;
					acc_q <= merged;
				end
			end
			if (take && finish) begin
				ovalid_q <= 1'b1;
			end else if (ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && finish) begin
			odata_q <= merged;
			ocnt_q  <= 4'(cnt_q) + 4'd1;
			olast_q <= sym.last;
			odone_q <= sym.done;
		end
	end

	assign valid       = ovalid_q;
	assign out_bytes   = odata_q;
	assign byte_count  = ocnt_q;
	assign last_of_run = olast_q;
	assign stream_done = odone_q;

endmodule

`default_nettype wire

// ----- src/packbits_run_length_encoder.sv -----
// PackBits run-length encoder. Image bytes arrive one per word in raster order, the
// last byte of an image flagged by end_of_image, and the coded stream leaves packed
// up to eight bytes per word, first byte in bits 7:0. Repeats of 2 to MAX_GROUP bytes
// are coded as header 257-n and the byte, literal groups of 1 to MAX_GROUP bytes as
// header n-1 and the bytes, and each image ends with the marker byte 128; a byte equal
// to a full repeat starts a new literal. The input is held while the sequencer works on
// each byte and while the coded bytes of a group it completes go out, one at a time
// through the sequencer and the single read port of the literal store; after a full
// literal group the new byte is written to the store in a state of its own, and the
// last byte of an image also sends its pending group and the end marker. The input
// is also held while the output word register waits to be taken.
// Depends on pbrle_pkg, pbrle_in_if, pbrle_out_if, pbrle_store, pbrle_seq, pbrle_pack.
`default_nettype none

module packbits_run_length_encoder #(
	parameter int MAX_GROUP = 128
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	pbrle_in_if.sink    pixels,
	pbrle_out_if.source codes
);

	pbrle_pkg::sym_t sym;
	logic            sym_ready;

	pbrle_seq #(.MAX_GROUP(MAX_GROUP)) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pixels.valid),
		.in_ready     (pixels.ready),
		.pixel        (pixels.pixel),
		.end_of_image (pixels.end_of_image),
		.sym          (sym),
		.sym_ready    (sym_ready)
	);

	pbrle_pack u_pack (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym         (sym),
		.sym_ready   (sym_ready),
		.valid       (codes.valid),
		.ready       (codes.ready),
		.out_bytes   (codes.out_bytes),
		.byte_count  (codes.byte_count),
		.last_of_run (codes.last_of_run),
		.stream_done (codes.stream_done)
	);

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the PackBits run-length encoder.
// Drives image bytes, predicts the coded words and checks every word from the block.
// Depends on pbrle_pkg, pbrle_in_if, pbrle_out_if and packbits_run_length_encoder.
`timescale 1ns / 100ps

module tb;

	localparam int MAX_GROUP = 128;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PHASE_ITEMS = 14;
	localparam int N_ROWS = 21;

	typedef struct packed {
		logic [63:0] out_bytes;
		logic [3:0]  byte_count;
		logic        last_of_run;
		logic        stream_done;
	} code_word_t;

	typedef struct packed {
		logic [7:0] px;
		logic       eoi;
		logic       typed;
		code_word_t want;
	} row_t;

	localparam code_word_t NO_WORD = '0;

	// Directed stimulus. Rows marked typed carry the single word they must produce;
	// the rest are checked against the predictor.
	row_t rows [0:N_ROWS-1] = '{
		'{8'hFF, 1'b1, 1'b1, {64'h0000_0000_0080_FF00, 4'd3, 1'b1, 1'b1}},
		'{8'h00, 1'b1, 1'b1, {64'h0000_0000_0080_0000, 4'd3, 1'b1, 1'b1}},
		'{8'h55, 1'b0, 1'b0, NO_WORD},
		'{8'h55, 1'b1, 1'b1, {64'h0000_0000_0080_55FF, 4'd3, 1'b1, 1'b1}},
		'{8'h01, 1'b0, 1'b0, NO_WORD},
		'{8'h02, 1'b0, 1'b0, NO_WORD},
		'{8'h02, 1'b0, 1'b1, {64'h0000_0000_0000_0100, 4'd2, 1'b1, 1'b0}},
		'{8'h03, 1'b1, 1'b1, {64'h0000_0080_0300_02FF, 4'd5, 1'b1, 1'b1}},
		'{8'h10, 1'b0, 1'b0, NO_WORD},
		'{8'h20, 1'b0, 1'b0, NO_WORD},
		'{8'h30, 1'b0, 1'b0, NO_WORD},
		'{8'h40, 1'b0, 1'b0, NO_WORD},
		'{8'h50, 1'b0, 1'b0, NO_WORD},
		'{8'h60, 1'b0, 1'b0, NO_WORD},
		'{8'h70, 1'b0, 1'b0, NO_WORD},
		'{8'h80, 1'b0, 1'b0, NO_WORD},
		'{8'h7F, 1'b1, 1'b0, NO_WORD},
		'{8'hAA, 1'b0, 1'b0, NO_WORD},
		'{8'hAA, 1'b0, 1'b0, NO_WORD},
		'{8'hAA, 1'b0, 1'b0, NO_WORD},
		'{8'h80, 1'b1, 1'b1, {64'h0000_0080_8000_AAFE, 4'd5, 1'b1, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pbrle_in_if  pix_ch ();
	pbrle_out_if code_ch ();

	packbits_run_length_encoder #(.MAX_GROUP(MAX_GROUP)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch),
		.codes  (code_ch)
	);

	// Predictor state, at its reset values.
	pbrle_pkg::mode_t pend_mode = pbrle_pkg::MODE_IDLE;
	int         pend_len = 0;
	logic [7:0] lit_store [0:MAX_GROUP-1];
	logic [7:0] prev_px = 8'h00;
	logic       have_prev = 1'b0;
	logic [7:0] coded_q [$];
	code_word_t pending_words [$];

	int         mismatches = 0;
	int         cycles = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	logic       typed_row = 1'b0;
	code_word_t typed_word = '0;
	logic [7:0] last_sent = 8'h00;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		pix_ch.valid = 1'b0;
		pix_ch.pixel = 8'h00;
		pix_ch.end_of_image = 1'b0;
		code_ch.ready = 1'b0;
	end

	always @(negedge clk) begin
		code_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycles,
				pending_words.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void append_byte(input logic [7:0] b);
		coded_q.insert(coded_q.size(), b);
	endfunction

	function automatic void append_word(input code_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic void put_literals(input int n);
		int i;
		if (n == 0)
			return;
		append_byte(8'(n - 1));
		for (i = 0; i < n; i++)
			append_byte(lit_store[i]);
	endfunction

	function automatic void put_run(input int n, input logic [7:0] b);
		logic [8:0] hdr;
		hdr = pbrle_pkg::RUN_HDR_BASE - 9'(n);
		append_byte(hdr[7:0]);
		append_byte(b);
	endfunction

	function automatic void hold_literal(input logic [7:0] b);
		lit_store[pend_len] = b;
		pend_len++;
		pend_mode = pbrle_pkg::MODE_LIT;
	endfunction

	// Works out the coded bytes for one accepted image byte and queues the words.
	function automatic void encode_byte(input logic [7:0] px, input logic eoi);
		code_word_t w;
		int nwords, k, i;
		coded_q.delete();
		if (have_prev && px == prev_px && pend_mode != pbrle_pkg::MODE_IDLE) begin
			if (pend_mode == pbrle_pkg::MODE_LIT) begin
				// The last literal joins its successor in a run of two.
				put_literals(pend_len - 1);
				pend_mode = pbrle_pkg::MODE_RUN;
				pend_len = 2;
			end else if (pend_len >= MAX_GROUP) begin
				// A full run is sent and the byte starts over as a single literal.
				put_run(pend_len, px);
				pend_len = 0;
				hold_literal(px);
			end else begin
				pend_len++;
			end
		end else begin
			if (pend_mode == pbrle_pkg::MODE_RUN) begin
				put_run(pend_len, prev_px);
				pend_mode = pbrle_pkg::MODE_IDLE;
			end else if (pend_mode == pbrle_pkg::MODE_LIT && pend_len >= MAX_GROUP) begin
				put_literals(pend_len);
				pend_mode = pbrle_pkg::MODE_IDLE;
			end
			if (pend_mode == pbrle_pkg::MODE_IDLE)
				pend_len = 0;
			hold_literal(px);
		end
		prev_px = px;
		have_prev = 1'b1;
		if (eoi) begin
			if (pend_mode == pbrle_pkg::MODE_LIT)
				put_literals(pend_len);
			else if (pend_mode == pbrle_pkg::MODE_RUN)
				put_run(pend_len, prev_px);
			append_byte(pbrle_pkg::END_MARK);
			pend_mode = pbrle_pkg::MODE_IDLE;
			pend_len = 0;
			prev_px = 8'h00;
			have_prev = 1'b0;
		end
		nwords = (coded_q.size() + 7) / 8;
		for (k = 0; k < nwords; k++) begin
			w = '0;
			for (i = 0; i < 8 && 8 * k + i < coded_q.size(); i++) begin
				w.out_bytes[8 * i +: 8] = coded_q[8 * k + i];
				w.byte_count = w.byte_count + 4'd1;
			end
			w.last_of_run = (k == nwords - 1);
			w.stream_done = eoi && (k == nwords - 1);
			append_word(w);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Prediction on input acceptance comes before the output check in the same
	// block, so a word leaving at the same edge always finds its expectation.
	always @(posedge clk) begin : monitor
		int depth;
		code_word_t got, want;
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready) begin
				depth = pending_words.size();
				encode_byte(pix_ch.pixel, pix_ch.end_of_image);
				if (typed_row) begin
					while (pending_words.size() > depth)
						void'(pending_words.pop_back());
					append_word(typed_word);
				end
			end
			if (code_ch.valid && code_ch.ready) begin
				got = '{code_ch.out_bytes, code_ch.byte_count, code_ch.last_of_run,
					code_ch.stream_done};
				if (pending_words.size() == 0) begin
					report_mismatch("unexpected word", got.out_bytes, 64'h0);
				end else begin
					want = pending_words.pop_front();
					if (got.out_bytes !== want.out_bytes)
						report_mismatch("out_bytes", got.out_bytes, want.out_bytes);
					if (got.byte_count !== want.byte_count)
						report_mismatch("byte_count", 64'(got.byte_count),
							64'(want.byte_count));
					if (got.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", 64'(got.last_of_run),
							64'(want.last_of_run));
					if (got.stream_done !== want.stream_done)
						report_mismatch("stream_done", 64'(got.stream_done),
							64'(want.stream_done));
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] px, input logic eoi, input logic typed,
		input code_word_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		typed_row = typed;
		typed_word = want;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		pix_ch.end_of_image <= eoi;
		last_sent = px;
		@(posedge clk);
		while (!pix_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_run(input int len);
		logic [7:0] v;
		v = 8'($urandom_range(255));
		repeat (len)
			send_byte(v, 1'b0, 1'b0, NO_WORD);
	endtask

	// Consecutive bytes always differ, so the whole stretch stays literal.
	task automatic send_literals(input int len);
		logic [7:0] v;
		repeat (len) begin
			v = 8'($urandom_range(255));
			if (v == last_sent)
				v = v + 8'd1;
			send_byte(v, 1'b0, 1'b0, NO_WORD);
		end
	endtask

	initial begin : stimulus
		int r, phase, budget, sel, len;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < N_ROWS; r++)
			send_byte(rows[r].px, rows[r].eoi, rows[r].typed, rows[r].want);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
			endcase
			if (phase == 2) begin
				// Hold the input back until every word owed so far has left.
				while (pending_words.size() != 0)
					@(posedge clk);
			end
			budget = PHASE_ITEMS;
			// A run past the full length, and a literal group past the full length.
			if (phase == 1) begin
				len = $urandom_range(MAX_GROUP + 1, MAX_GROUP + 3);
				send_run(len);
				budget -= len;
			end
			if (phase == 2) begin
				len = $urandom_range(MAX_GROUP + 1, MAX_GROUP + 4);
				send_literals(len);
				budget -= len;
			end
			while (budget > 0) begin
				sel = $urandom_range(15);
				if (sel < 6) begin
					len = $urandom_range(2, 6);
					send_run(len);
				end else if (sel < 12) begin
					len = $urandom_range(1, 8);
					send_literals(len);
				end else if (sel < 14) begin
					len = 1;
					send_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_WORD);
				end else begin
					len = $urandom_range(1, 4);
					repeat (len)
						send_byte(8'($urandom_range(255)), ($urandom_range(7) == 0),
							1'b0, NO_WORD);
				end
				budget -= len;
			end
		end
		send_byte(8'($urandom_range(255)), 1'b1, 1'b0, NO_WORD);
		@(negedge clk);
		pix_ch.valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
